// ===== sv/hfbf_pkg.sv =====
// Package for the humidity frame to bus float converter.
// Holds field widths, status and register index codes, and the bus float packer.
// No dependencies.
package hfbf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned TempW   = 17;
  localparam int unsigned HumidW  = 18;
  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MantW   = 11;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FAULT    = 2'd1,
    STATUS_CHECKSUM = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENSOR_KIND  = 2'd0,
    REG_TEMP_OFFSET  = 2'd1,
    REG_HUMID_OFFSET = 2'd2,
    REG_SEND_FORMAT  = 2'd3
  } cfg_reg_e;

  localparam logic [KindW-1:0] KIND_SINGLE_BYTE = 2'd0;
  localparam logic [1:0]       FLOAT_EXP        = 2'd3;

  // Pack tenths as a 2-byte bus float, exponent 3, bytes swapped.
  function automatic logic [WordW-1:0] pack_word(input logic signed [HumidW-1:0] tenths);
    logic signed [HumidW+2:0] scaled;
    logic signed [HumidW+2:0] adj;
    logic signed [HumidW+2:0] mant;
    logic        [WordW-1:0]  w;
    scaled = (HumidW+3)'(tenths) + ((HumidW+3)'(tenths) <<< 2);
    adj    = scaled + ((tenths < 0) ? (HumidW+3)'(3) : (HumidW+3)'(0));
    mant   = adj >>> 2;
    w      = {(tenths < 0), 2'b00, FLOAT_EXP, mant[MantW-1:0]};
    return {w[7:0], w[15:8]};
  endfunction

endpackage

// ===== sv/humidity_frame_to_bus_float_top.sv =====
// Top level of the humidity frame to bus float converter.
// Throughput: one transaction per cycle unless a held result with out_ready_i low stalls the pipeline.
// An input register feeds the decode logic, which feeds the result register.
// Reset clears the stage valid flags and loads the register defaults
// (single-byte sensor, zero offsets, bus words enabled).
// Depends on hfbf_pkg.
module humidity_frame_to_bus_float_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hfbf_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [hfbf_pkg::ByteW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [hfbf_pkg::ByteW-1:0]           frame_b0_i,
  input  logic [hfbf_pkg::ByteW-1:0]           frame_b1_i,
  input  logic [hfbf_pkg::ByteW-1:0]           frame_b2_i,
  input  logic [hfbf_pkg::ByteW-1:0]           frame_b3_i,
  input  logic [hfbf_pkg::ByteW-1:0]           frame_sum_i,
  input  logic [hfbf_pkg::ByteW-1:0]           read_fault_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hfbf_pkg::StatusW-1:0]         status_o,
  output logic signed [hfbf_pkg::TempW-1:0]    temp_tenths_o,
  output logic signed [hfbf_pkg::HumidW-1:0]   humid_tenths_o,
  output logic [hfbf_pkg::WordW-1:0]           temp_word_o,
  output logic [hfbf_pkg::WordW-1:0]           humid_word_o,
  output logic                                 words_valid_o
);

  logic [hfbf_pkg::KindW-1:0]       kind_q;
  logic signed [hfbf_pkg::ByteW-1:0] toff_q;
  logic signed [hfbf_pkg::ByteW-1:0] hoff_q;
  logic                             fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0;
      toff_q <= '0;
      hoff_q <= '0;
      fmt_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (hfbf_pkg::cfg_reg_e'(cfg_idx_i))
        hfbf_pkg::REG_SENSOR_KIND:  kind_q <= cfg_data_i[hfbf_pkg::KindW-1:0];
        hfbf_pkg::REG_TEMP_OFFSET:  toff_q <= cfg_data_i;
        hfbf_pkg::REG_HUMID_OFFSET: hoff_q <= cfg_data_i;
        hfbf_pkg::REG_SEND_FORMAT:  fmt_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic s1_valid_q, s2_valid_q;
  logic s2_load, s1_load;

  assign s2_load    = s1_valid_q & (~s2_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s2_load;
  assign s1_load    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Input register
  logic [hfbf_pkg::ByteW-1:0] b0_q, b1_q, b2_q, b3_q, sum_q, fault_q;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      b0_q    <= frame_b0_i;
      b1_q    <= frame_b1_i;
      b2_q    <= frame_b2_i;
      b3_q    <= frame_b3_i;
      sum_q   <= frame_sum_i;
      fault_q <= read_fault_i;
    end
  end

  // Decode
  logic [hfbf_pkg::ByteW-1:0]         csum;
  logic [15:0]                        h_raw;
  logic [14:0]                        t_mag;
  logic signed [hfbf_pkg::TempW-1:0]  t_dec;
  logic signed [hfbf_pkg::HumidW-1:0] h_dec;
  logic [hfbf_pkg::StatusW-1:0]       status_d;
  logic signed [hfbf_pkg::TempW-1:0]  temp_d;
  logic signed [hfbf_pkg::HumidW-1:0] humid_d;
  logic                               wvalid_d;
  logic [hfbf_pkg::WordW-1:0]         tword_d, hword_d;

  always_comb begin
    csum = b0_q + b1_q + b2_q + b3_q;
    if (kind_q == hfbf_pkg::KIND_SINGLE_BYTE) begin
      h_raw = (16'(b0_q) << 3) + (16'(b0_q) << 1);
      t_mag = (15'(b2_q[6:0]) << 3) + (15'(b2_q[6:0]) << 1);
    end else begin
      h_raw = {b0_q, b1_q};
      t_mag = {b2_q[6:0], b3_q};
    end
    t_dec = b2_q[7] ? -hfbf_pkg::TempW'(t_mag) : hfbf_pkg::TempW'(t_mag);
    t_dec = t_dec + hfbf_pkg::TempW'(toff_q);
    h_dec = hfbf_pkg::HumidW'(h_raw) + hfbf_pkg::HumidW'(hoff_q);

    if (fault_q != '0) begin
      status_d = hfbf_pkg::STATUS_FAULT;
      temp_d   = '0;
      humid_d  = '0;
    end else begin
      status_d = (csum == sum_q) ? hfbf_pkg::STATUS_OK : hfbf_pkg::STATUS_CHECKSUM;
      temp_d   = t_dec;
      humid_d  = h_dec;
    end

    wvalid_d = (status_d == hfbf_pkg::STATUS_OK) & fmt_q;
    tword_d  = wvalid_d ? hfbf_pkg::pack_word(hfbf_pkg::HumidW'(temp_d)) : '0;
    hword_d  = wvalid_d ? hfbf_pkg::pack_word(humid_d) : '0;
  end

  // Result register
  logic [hfbf_pkg::StatusW-1:0]       status_q;
  logic signed [hfbf_pkg::TempW-1:0]  temp_q;
  logic signed [hfbf_pkg::HumidW-1:0] humid_q;
  logic [hfbf_pkg::WordW-1:0]         tword_q, hword_q;
  logic                               wvalid_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      status_q <= status_d;
      temp_q   <= temp_d;
      humid_q  <= humid_d;
      tword_q  <= tword_d;
      hword_q  <= hword_d;
      wvalid_q <= wvalid_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign status_o       = status_q;
  assign temp_tenths_o  = temp_q;
  assign humid_tenths_o = humid_q;
  assign temp_word_o    = tword_q;
  assign humid_word_o   = hword_q;
  assign words_valid_o  = wvalid_q;

endmodule
